### rtl/snap_to_segment_intersection_assert.svh
// Assertion macros shared by the snap-to-intersection RTL.
`ifndef SNAP_TO_SEGMENT_INTERSECTION_ASSERT_SVH
`define SNAP_TO_SEGMENT_INTERSECTION_ASSERT_SVH
// same-cycle implication, clocked on clk, off during reset
`define STSI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define STSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/stsi_pkg.sv
// Shared constants, types and helpers for the snap-to-intersection block.
`default_nettype none
package stsi_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic vld;
		logic hit;
	} ctl_t;

	// width of one queue entry for coordinate width w
	function automatic int entry_bits(input int w);
		return 12 * w + 5;
	endfunction
endpackage
`default_nettype wire

### rtl/stsi_front.sv
// Front end: segment differences, cross products and the hit classification.
`default_nettype none
module stsi_front #(
	parameter int W = stsi_pkg::COORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [W-1:0]         query_x,
	input  wire logic [W-1:0]         query_y,
	input  wire logic [W-1:0]         query_z,
	input  wire logic [W-1:0]         seg1_start_x,
	input  wire logic [W-1:0]         seg1_start_y,
	input  wire logic [W-1:0]         seg1_start_z,
	input  wire logic [W-1:0]         seg1_end_x,
	input  wire logic [W-1:0]         seg1_end_y,
	input  wire logic [W-1:0]         seg2_start_x,
	input  wire logic [W-1:0]         seg2_start_y,
	input  wire logic [W-1:0]         seg2_end_x,
	input  wire logic [W-1:0]         seg2_end_y,
	output logic                      push,
	output logic [stsi_pkg::entry_bits(W)-1:0] entry
);
	localparam int PW = 2 * W + 2;
	localparam int NW = PW + 1;
	localparam int UW = 2 * W + 1;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [W:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic [6*W-1:0] pt_s1, pt_s2, pt_s3;
	logic signed [PW-1:0] ab_s2, cd_s2, eb_s2, fd_s2, ce_s2, af_s2;
	logic [W-1:0] mx_s2, my_s2, mx_s3, my_s3;
	logic dxn_s2, dyn_s2, dxn_s3, dyn_s3;
	logic signed [NW-1:0] den_s3, tn_s3, un_s3;
	logic signed [NW-1:0] den_a, tn_a, un_a;
	logic hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= {seg1_start_x[W-1], seg1_start_x} - {seg1_end_x[W-1], seg1_end_x};
		b_s1  <= {seg2_start_y[W-1], seg2_start_y} - {seg2_end_y[W-1], seg2_end_y};
		c_s1  <= {seg1_start_y[W-1], seg1_start_y} - {seg1_end_y[W-1], seg1_end_y};
		d_s1  <= {seg2_start_x[W-1], seg2_start_x} - {seg2_end_x[W-1], seg2_end_x};
		e_s1  <= {seg1_start_x[W-1], seg1_start_x} - {seg2_start_x[W-1], seg2_start_x};
		f_s1  <= {seg1_start_y[W-1], seg1_start_y} - {seg2_start_y[W-1], seg2_start_y};
		pt_s1 <= {query_x, query_y, query_z, seg1_start_x, seg1_start_y, seg1_start_z};

		ab_s2  <= a_s1 * b_s1;
		cd_s2  <= c_s1 * d_s1;
		eb_s2  <= e_s1 * b_s1;
		fd_s2  <= f_s1 * d_s1;
		ce_s2  <= c_s1 * e_s1;
		af_s2  <= a_s1 * f_s1;
		// direction is end minus start, the negation of a and c
		mx_s2  <= a_s1[W] ? W'(-a_s1) : W'(a_s1);
		my_s2  <= c_s1[W] ? W'(-c_s1) : W'(c_s1);
		dxn_s2 <= !a_s1[W];
		dyn_s2 <= !c_s1[W];
		pt_s2  <= pt_s1;

		den_s3 <= ab_s2 - cd_s2;
		tn_s3  <= eb_s2 - fd_s2;
		un_s3  <= ce_s2 - af_s2;
		mx_s3  <= mx_s2;
		my_s3  <= my_s2;
		dxn_s3 <= dxn_s2;
		dyn_s3 <= dyn_s2;
		pt_s3  <= pt_s2;
	end

	// flip signs so the denominator is positive, then range-check t and u
	always_comb begin
		den_a = den_s3[NW-1] ? -den_s3 : den_s3;
		tn_a  = den_s3[NW-1] ? -tn_s3  : tn_s3;
		un_a  = den_s3[NW-1] ? -un_s3  : un_s3;
		hit   = (den_s3 != '0) && !tn_a[NW-1] && (tn_a <= den_a)
			&& !un_a[NW-1] && (un_a <= den_a);
	end

	assign push  = vld_s3;
	assign entry = {hit, den_a[UW-1:0], tn_a[UW-1:0], dxn_s3, mx_s3, dyn_s3, my_s3, pt_s3};
endmodule
`default_nettype wire

### rtl/stsi_queue.sv
// Small FIFO between the front end and the back end.
`default_nettype none
`include "snap_to_segment_intersection_assert.svh"
module stsi_queue #(
	parameter int EW    = stsi_pkg::entry_bits(stsi_pkg::COORD_BITS_DEF),
	parameter int DEPTH = stsi_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [EW-1:0] din,
	input  wire logic          pop,
	output logic [EW-1:0]      dout,
	output logic               empty,
	output logic               full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [EW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));
	assign do_pop  = pop && !empty;
	assign do_push = push && (!full || do_pop);
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	`STSI_ASSERT_IMPL(a_no_overflow, push && full, pop, "queue beat dropped while full")
	`STSI_ASSERT_NEXT(a_push_lands, push && !pop && !full, !empty, "pushed beat not in queue")
endmodule
`default_nettype wire

### rtl/stsi_back.sv
// Back end: interpolation with a pipelined divider, then the snap distance test.
`default_nettype none
`include "snap_to_segment_intersection_assert.svh"
module stsi_back #(
	parameter int W = stsi_pkg::COORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire logic [stsi_pkg::entry_bits(W)-1:0] in_entry,
	input  wire logic [W-2:0]         snap_radius,
	output logic                      done,
	output logic [W-1:0]              out_x,
	output logic [W-1:0]              out_y,
	output logic [W-1:0]              out_z,
	output logic                      snapped
);
	localparam int UW    = 2 * W + 1;
	localparam int H     = (UW + 1) / 2;
	localparam int PRW   = UW + W;
	localparam int RW    = PRW + 2;
	localparam int SW    = 6 * W + 2;
	localparam int P_MY  = 6 * W;
	localparam int P_DYN = 7 * W;
	localparam int P_MX  = 7 * W + 1;
	localparam int P_DXN = 8 * W + 1;
	localparam int P_TN  = 8 * W + 2;
	localparam int P_DEN = P_TN + UW;
	localparam int P_HIT = P_DEN + UW;
	localparam int LAT   = W + 5;
	localparam int DSW   = 2 * W + 5;

	logic [UW-1:0] tn, den;
	logic [W-1:0] mx, my;
	logic [SW-1:0] side;

	assign tn   = in_entry[P_TN +: UW];
	assign den  = in_entry[P_DEN +: UW];
	assign mx   = in_entry[P_MX +: W];
	assign my   = in_entry[P_MY +: W];
	assign side = {in_entry[P_DXN], in_entry[P_DYN], in_entry[6*W-1:0]};

	stsi_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	stsi_pkg::ctl_t ctl_sd [W+1];
	logic [H+W-1:0] pxl_s1, pyl_s1;
	logic [UW-H+W-1:0] pxh_s1, pyh_s1;
	logic [UW-1:0] den_s1;
	logic [SW-1:0] side_s1, side_s2;
	logic [RW-1:0] nx_s2, ny_s2;
	logic [UW:0] dd_s2;

	logic [RW-1:0] rx_sd [W+1];
	logic [RW-1:0] ry_sd [W+1];
	logic [W-1:0] qx_sd [W+1];
	logic [W-1:0] qy_sd [W+1];
	logic [UW:0] dd_sd [W+1];
	logic [SW-1:0] side_sd [W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, hit: in_entry[P_HIT]};
			ctl_s2 <= ctl_s1;
		end
	end

	// t numerator times direction, split into two partial products
	always_ff @(posedge clk) begin
		pxl_s1  <= tn[H-1:0] * mx;
		pxh_s1  <= tn[UW-1:H] * mx;
		pyl_s1  <= tn[H-1:0] * my;
		pyh_s1  <= tn[UW-1:H] * my;
		den_s1  <= den;
		side_s1 <= side;

		// round to nearest: (2p + den) / (2 den)
		nx_s2   <= {PRW'(pxl_s1) + (PRW'(pxh_s1) << H), 1'b0} + RW'(den_s1);
		ny_s2   <= {PRW'(pyl_s1) + (PRW'(pyh_s1) << H), 1'b0} + RW'(den_s1);
		dd_s2   <= {den_s1, 1'b0};
		side_s2 <= side_s1;
	end

	assign ctl_sd[0]  = ctl_s2;
	assign rx_sd[0]   = nx_s2;
	assign ry_sd[0]   = ny_s2;
	assign qx_sd[0]   = '0;
	assign qy_sd[0]   = '0;
	assign dd_sd[0]   = dd_s2;
	assign side_sd[0] = side_s2;

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 0; k < W; k++) begin : g_div
		localparam int SH = W - 1 - k;
		logic [RW-1:0] shd;
		logic gex, gey;
		assign shd = RW'(dd_sd[k]) << SH;
		assign gex = (rx_sd[k] >= shd);
		assign gey = (ry_sd[k] >= shd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_sd[k+1] <= '0;
			else ctl_sd[k+1] <= ctl_sd[k];
		end

		always_ff @(posedge clk) begin
			rx_sd[k+1]   <= gex ? rx_sd[k] - shd : rx_sd[k];
			ry_sd[k+1]   <= gey ? ry_sd[k] - shd : ry_sd[k];
			qx_sd[k+1]   <= {qx_sd[k][W-2:0], gex};
			qy_sd[k+1]   <= {qy_sd[k][W-2:0], gey};
			dd_sd[k+1]   <= dd_sd[k];
			side_sd[k+1] <= side_sd[k];
		end
	end

	logic [SW-1:0] sdv;
	logic [W-1:0] qxv, qyv, qzv, x1v, y1v, z1v;
	logic [W:0] ixf, iyf;

	assign sdv = side_sd[W];
	assign qxv = sdv[6*W-1:5*W];
	assign qyv = sdv[5*W-1:4*W];
	assign qzv = sdv[4*W-1:3*W];
	assign x1v = sdv[3*W-1:2*W];
	assign y1v = sdv[2*W-1:W];
	assign z1v = sdv[W-1:0];
	assign ixf = sdv[SW-1] ? {x1v[W-1], x1v} - {1'b0, qx_sd[W]}
		: {x1v[W-1], x1v} + {1'b0, qx_sd[W]};
	assign iyf = sdv[SW-2] ? {y1v[W-1], y1v} - {1'b0, qy_sd[W]}
		: {y1v[W-1], y1v} + {1'b0, qy_sd[W]};

	logic [W-1:0] ix_s3, iy_s3, ix_s4, iy_s4;
	logic [W-1:0] qx_s3, qy_s3, qz_s3, z1_s3, qx_s4, qy_s4, qz_s4, z1_s4;
	logic signed [W+1:0] dx_s3, dy_s3, dz_s3;
	logic signed [2*W+3:0] sqx_s4, sqy_s4, sqz_s4;
	logic [2*W-3:0] rr_s4;
	logic [DSW-1:0] dist_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s3 <= ctl_sd[W];
			ctl_s4 <= ctl_s3;
			done   <= ctl_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		ix_s3  <= ixf[W-1:0];
		iy_s3  <= iyf[W-1:0];
		dx_s3  <= {ixf[W], ixf} - {{2{qxv[W-1]}}, qxv};
		dy_s3  <= {iyf[W], iyf} - {{2{qyv[W-1]}}, qyv};
		dz_s3  <= {{2{z1v[W-1]}}, z1v} - {{2{qzv[W-1]}}, qzv};
		qx_s3  <= qxv;
		qy_s3  <= qyv;
		qz_s3  <= qzv;
		z1_s3  <= z1v;

		sqx_s4 <= dx_s3 * dx_s3;
		sqy_s4 <= dy_s3 * dy_s3;
		sqz_s4 <= dz_s3 * dz_s3;
		rr_s4  <= snap_radius * snap_radius;
		ix_s4  <= ix_s3;
		iy_s4  <= iy_s3;
		qx_s4  <= qx_s3;
		qy_s4  <= qy_s3;
		qz_s4  <= qz_s3;
		z1_s4  <= z1_s3;
	end

	assign dist_sq = DSW'(unsigned'(sqx_s4)) + DSW'(unsigned'(sqy_s4))
		+ DSW'(unsigned'(sqz_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snapped <= 1'b0;
		end else begin
			snapped <= ctl_s4.vld && ctl_s4.hit && (DSW'(rr_s4) >= dist_sq);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s4.hit && (DSW'(rr_s4) >= dist_sq)) begin
			out_x <= ix_s4;
			out_y <= iy_s4;
			out_z <= z1_s4;
		end else begin
			out_x <= qx_s4;
			out_y <= qy_s4;
			out_z <= qz_s4;
		end
	end

	`STSI_ASSERT_IMPL(a_latency, done, $past(in_vld, LAT), "result beat without matching entry")
	`STSI_ASSERT_IMPL(a_snap_strobe, snapped, done, "snapped flag outside a result beat")
endmodule
`default_nettype wire

### rtl/snap_to_segment_intersection.sv
// Top level: snap a query point to the XY crossing of two segments.
//
// Usage:
//  - An item is taken at a rising edge with start high and busy low. The
//    twelve coordinate ports carry the query point and both segments.
//  - Each result is shown for one cycle with done high: out_x/out_y/out_z and
//    snapped. The receiver cannot stall; every result must be taken as shown.
//  - From accept to done a result passes three front stages, one queue slot,
//    the interpolation divider and then five arithmetic stages.
//  - Throughput is one item per cycle; the divider is fully pipelined and the
//    back end drains the queue every cycle, so busy stays low in steady use.
//  - snap_radius is written over cfg_valid/cfg_ready/cfg_data; the user must do
//    so only while idle, which the block does not enforce. cfg_ready is always high.
//  - Reset (arst_n low) clears control flags, queue pointers and snap_radius.
`default_nettype none
module snap_to_segment_intersection #(
	parameter int COORD_BITS = stsi_pkg::COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COORD_BITS-1:0] query_x,
	input  wire logic [COORD_BITS-1:0] query_y,
	input  wire logic [COORD_BITS-1:0] query_z,
	input  wire logic [COORD_BITS-1:0] seg1_start_x,
	input  wire logic [COORD_BITS-1:0] seg1_start_y,
	input  wire logic [COORD_BITS-1:0] seg1_start_z,
	input  wire logic [COORD_BITS-1:0] seg1_end_x,
	input  wire logic [COORD_BITS-1:0] seg1_end_y,
	input  wire logic [COORD_BITS-1:0] seg2_start_x,
	input  wire logic [COORD_BITS-1:0] seg2_start_y,
	input  wire logic [COORD_BITS-1:0] seg2_end_x,
	input  wire logic [COORD_BITS-1:0] seg2_end_y,
	output logic                       done,
	output logic [COORD_BITS-1:0]      out_x,
	output logic [COORD_BITS-1:0]      out_y,
	output logic [COORD_BITS-1:0]      out_z,
	output logic                       snapped,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [COORD_BITS-2:0] cfg_data
);
	localparam int EW = stsi_pkg::entry_bits(COORD_BITS);

	logic [COORD_BITS-2:0] snap_radius_q;
	logic push, empty, full;
	logic [EW-1:0] entry, head;

	assign cfg_ready = 1'b1;
	assign busy      = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) snap_radius_q <= '0;
		else if (cfg_valid) snap_radius_q <= cfg_data;
	end

	stsi_front #(.W(COORD_BITS)) u_front (
		.clk, .arst_n, .start, .busy,
		.query_x, .query_y, .query_z,
		.seg1_start_x, .seg1_start_y, .seg1_start_z, .seg1_end_x, .seg1_end_y,
		.seg2_start_x, .seg2_start_y, .seg2_end_x, .seg2_end_y,
		.push, .entry
	);

	stsi_queue #(.EW(EW), .DEPTH(stsi_pkg::QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .din(entry), .pop(!empty), .dout(head), .empty, .full
	);

	stsi_back #(.W(COORD_BITS)) u_back (
		.clk, .arst_n, .in_vld(!empty), .in_entry(head), .snap_radius(snap_radius_q),
		.done, .out_x, .out_y, .out_z, .snapped
	);
endmodule
`default_nettype wire
